/* src/bdlp_pkg.sv */
// Shared types and constants for the button debounce, long press and repeat unit.
package bdlp_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned CFG_W = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_TIME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_INTERVAL = 2'd2;

   localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST = 16'd20;
   localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST = 16'd500;
   localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd100;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_time;
      logic [CFG_W-1:0] long_press_time;
      logic [CFG_W-1:0] repeat_interval;
   } cfg_type;

   typedef struct packed {
      logic press_event;
      logic release_event;
      logic repeat_event;
      logic held;
   } event_type;

endpackage

/* src/button_debounce_long_press_repeat_unit.sv */
// Top level of the button debounce, long press and auto-repeat unit.
// Each request carries a raw active-low button level and a millisecond timestamp and yields
// exactly one response with press, release and repeat pulses and the debounced held level.
// A request is taken when req_tready is high: an input register holds it, the state update
// and event decision are done in subtract-and-compare logic against the timing registers,
// and an output register holds the response: one request per cycle while rsp_tready is
// high. The user must write timing registers via the csr_ port while idle (unenforced).
module button_debounce_long_press_repeat_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] raw_level, [32:1] time_ms, [39:33] zero
   input  logic [bdlp_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] press_event, [1] release_event, [2] repeat_event, [3] held, [7:4] zero
   output logic [bdlp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [bdlp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bdlp_pkg::CFG_W-1:0]          csr_wdata
);

   bdlp_pkg::cfg_type   cfg;
   bdlp_pkg::event_type events;

   logic                        in_valid_ff, in_valid_in;
   logic                        in_raw_ff;
   logic [bdlp_pkg::TIME_W-1:0] in_time_ff;
   logic                        out_valid_ff, out_valid_in;
   bdlp_pkg::event_type         out_ev_ff;
   logic                        out_free, step, take;

   bdlp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bdlp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .raw_level (in_raw_ff),
      .time_ms   (in_time_ff),
      .events    (events)
   );

   always_comb begin
      out_free = !out_valid_ff || rsp_tready;
      step = in_valid_ff && out_free;
      req_tready = !in_valid_ff || out_free;
      take = req_tvalid && req_tready;
      in_valid_in = take ? 1'b1 : (in_valid_ff && !out_free);
      out_valid_in = step ? 1'b1 : (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_raw_ff <= req_tdata[0];
         in_time_ff <= req_tdata[bdlp_pkg::TIME_W:1];
      end
      if (step) begin
         out_ev_ff <= events;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {4'd0, out_ev_ff.held, out_ev_ff.repeat_event,
                       out_ev_ff.release_event, out_ev_ff.press_event};

endmodule

/* src/bdlp_csr.sv */
// Configuration registers for debounce, long-press and repeat timing.
module bdlp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bdlp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bdlp_pkg::CFG_W-1:0]     csr_wdata,
   output bdlp_pkg::cfg_type              cfg
);

   bdlp_pkg::cfg_type cfg_ff;
   bdlp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            bdlp_pkg::CSR_DEBOUNCE_TIME:   cfg_in.debounce_time = csr_wdata;
            bdlp_pkg::CSR_LONG_PRESS_TIME: cfg_in.long_press_time = csr_wdata;
            bdlp_pkg::CSR_REPEAT_INTERVAL: cfg_in.repeat_interval = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time <= bdlp_pkg::DEBOUNCE_TIME_RST;
         cfg_ff.long_press_time <= bdlp_pkg::LONG_PRESS_TIME_RST;
         cfg_ff.repeat_interval <= bdlp_pkg::REPEAT_INTERVAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/bdlp_core.sv */
// Debounce, long-press and repeat state with its per-request update logic.
module bdlp_core (
   input  logic                        clock,
   input  logic                        reset,
   input  bdlp_pkg::cfg_type           cfg,
   input  logic                        step,
   input  logic                        raw_level,
   input  logic [bdlp_pkg::TIME_W-1:0] time_ms,
   output bdlp_pkg::event_type         events
);

   logic                        last_raw_ff, last_raw_in;
   logic                        stable_ff, stable_in;
   logic                        long_on_ff, long_on_in;
   logic [bdlp_pkg::TIME_W-1:0] change_time_ff, change_time_in;
   logic [bdlp_pkg::TIME_W-1:0] press_start_ff, press_start_in;
   logic [bdlp_pkg::TIME_W-1:0] last_repeat_ff, last_repeat_in;

   logic [bdlp_pkg::TIME_W-1:0] d_change, d_press, d_repeat;
   logic raw_changed, edge_seen, press, release_ev, long_kept, press_due;
   logic enter_long, rebase, repeat_due, repeat_ev;

   always_comb begin
      d_change = time_ms - change_time_ff;
      d_press = time_ms - press_start_ff;
      d_repeat = time_ms - last_repeat_ff;
      raw_changed = raw_level != last_raw_ff;
      edge_seen = !raw_changed && (d_change > {16'd0, cfg.debounce_time}) &&
                  (raw_level != stable_ff);
      press = edge_seen && !raw_level;
      release_ev = edge_seen && raw_level;
      stable_in = edge_seen ? raw_level : stable_ff;
      long_kept = edge_seen ? 1'b0 : long_on_ff;
      press_due = press ? (cfg.long_press_time == '0)
                        : (d_press >= {16'd0, cfg.long_press_time});
      enter_long = !long_kept && !stable_in && press_due;
      long_on_in = long_kept || enter_long;
      rebase = press || enter_long;
      repeat_due = rebase ? (cfg.repeat_interval == '0)
                          : (d_repeat >= {16'd0, cfg.repeat_interval});
      repeat_ev = long_on_in && !stable_in && repeat_due;
      last_repeat_in = (rebase || repeat_ev) ? time_ms : last_repeat_ff;
      press_start_in = press ? time_ms : press_start_ff;
      change_time_in = raw_changed ? time_ms : change_time_ff;
      last_raw_in = raw_level;

      events.press_event = press;
      events.release_event = release_ev;
      events.repeat_event = repeat_ev;
      events.held = !stable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff <= 1'b1;
         stable_ff <= 1'b1;
         long_on_ff <= 1'b0;
         change_time_ff <= '0;
         press_start_ff <= '0;
         last_repeat_ff <= '0;
      end else if (step) begin
         last_raw_ff <= last_raw_in;
         stable_ff <= stable_in;
         long_on_ff <= long_on_in;
         change_time_ff <= change_time_in;
         press_start_ff <= press_start_in;
         last_repeat_ff <= last_repeat_in;
      end
   end

endmodule
